>>> rtl/core/pbcq_pkg.sv
`default_nettype none

package pbcq_pkg;

   // Field and datapath widths
   localparam int COORD_WIDTH      = 32;
   localparam int MARGIN_WIDTH     = 24;
   localparam int DIST_WIDTH       = 32;
   localparam int NORM_WIDTH       = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int ADDR_WIDTH       = 5;
   localparam int DATA_WIDTH       = 32;

   // Extended coordinate width: box grown by two margins plus a difference
   localparam int EXT_WIDTH   = 36;
   // Corner components are scaled below 2^31 before squaring
   localparam int SMALL_WIDTH = 31;
   localparam int RAD_WIDTH   = 64;
   localparam int ROOT_WIDTH  = RAD_WIDTH / 2;
   localparam int REM_WIDTH   = ROOT_WIDTH + 2;
   localparam int QUOT_WIDTH  = NORMAL_FRAC_BITS + 1;
   localparam int NUM_WIDTH   = SMALL_WIDTH + NORMAL_FRAC_BITS + 1;

   localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = MARGIN_WIDTH'(655360);

   localparam logic [DIST_WIDTH-1:0] DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_WIDTH-1:0] DIST_HI =
      {{(EXT_WIDTH-DIST_WIDTH+1){1'b0}}, {(DIST_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_WIDTH-1:0] DIST_LO =
      {{(EXT_WIDTH-DIST_WIDTH+1){1'b1}}, {(DIST_WIDTH-1){1'b0}}};

   // Register map, index = paddr / 4
   typedef enum logic [2:0] {
      REG_MIN_X,
      REG_MIN_Y,
      REG_MAX_X,
      REG_MAX_Y,
      REG_MARGIN
   } pbcq_reg_type;

   // Region class of a query point
   typedef enum logic [1:0] {
      KIND_NEAR,
      KIND_FACE,
      KIND_CORNER
   } pbcq_kind_type;

   // Data that rides along the pipeline beside the root and divide units
   typedef struct packed {
      logic                   corner;
      logic                   big;
      logic                   neg_x;
      logic                   neg_y;
      logic [SMALL_WIDTH-1:0] sx;
      logic [SMALL_WIDTH-1:0] sy;
      logic [DIST_WIDTH-1:0]  face_dist;
      logic [NORM_WIDTH-1:0]  nx;
      logic [NORM_WIDTH-1:0]  ny;
   } pbcq_side_type;

   function automatic logic [DIST_WIDTH-1:0] sat_dist(input logic signed [EXT_WIDTH-1:0] v);
      logic [DIST_WIDTH-1:0] r;
      if (v > DIST_HI) r = DIST_HI[DIST_WIDTH-1:0];
      else if (v < DIST_LO) r = DIST_LO[DIST_WIDTH-1:0];
      else r = v[DIST_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic [NORM_WIDTH-1:0] axis_unit(input logic neg);
      logic [NORM_WIDTH-1:0] one;
      one = NORM_WIDTH'(1) << NORMAL_FRAC_BITS;
      return neg ? (~one + NORM_WIDTH'(1)) : one;
   endfunction

   function automatic logic [EXT_WIDTH-1:0] magnitude(input logic signed [EXT_WIDTH-1:0] v);
      return v[EXT_WIDTH-1] ? (~v + EXT_WIDTH'(1)) : v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/pbcq_classify.sv
`default_nettype none

module pbcq_classify import pbcq_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] box_min_x,
   input  logic signed [COORD_WIDTH-1:0] box_min_y,
   input  logic signed [COORD_WIDTH-1:0] box_max_x,
   input  logic signed [COORD_WIDTH-1:0] box_max_y,
   input  logic [MARGIN_WIDTH-1:0]       margin,
   output logic                          out_valid,
   output pbcq_side_type                 out_side
);

   logic signed [EXT_WIDTH-1:0] px, py, bx0, by0, bx1, by1, e, e2, g;
   logic signed [EXT_WIDTH-1:0] lox, loy, hix, hiy;
   logic                        inner;

   // stage 1 registers
   logic                        v1_ff;
   pbcq_kind_type               kind_in, kind_ff;
   logic                        band_in, band_ff;
   logic                        axis_in, axis_ff;
   logic                        neg_in, neg_ff;
   logic signed [EXT_WIDTH-1:0] c_in [4];
   logic signed [EXT_WIDTH-1:0] c_ff [4];

   // stage 2
   logic                        v2_ff;
   pbcq_side_type               side_in, side_ff;
   logic signed [EXT_WIDTH-1:0] best, nearv;
   logic [1:0]                  bi;
   logic [EXT_WIDTH-1:0]        ax, ay, am, shx, shy;
   logic [1:0]                  sh;

   assign px  = EXT_WIDTH'(point_x);
   assign py  = EXT_WIDTH'(point_y);
   assign bx0 = EXT_WIDTH'(box_min_x);
   assign by0 = EXT_WIDTH'(box_min_y);
   assign bx1 = EXT_WIDTH'(box_max_x);
   assign by1 = EXT_WIDTH'(box_max_y);
   assign e   = EXT_WIDTH'(margin);
   assign e2  = e + e;
   assign lox = bx0 - e2;
   assign loy = by0 - e2;
   assign hix = bx1 + e2;
   assign hiy = by1 + e2;

   // Region classification and face candidates
   always_comb begin
      inner   = !(px < bx0 - e || py < by0 - e || px > bx1 + e || py > by1 + e);
      g       = inner ? '0 : e2;
      band_in = !inner;
      kind_in = KIND_NEAR;
      axis_in = 1'b0;
      neg_in  = 1'b0;
      c_in[0] = px - bx0 + g;
      c_in[1] = bx1 + g - px;
      c_in[2] = py - by0 + g;
      c_in[3] = by1 + g - py;
      if (inner) begin
         band_in = 1'b0;
      end else if (px < lox) begin
         if (py > hiy) begin
            kind_in = KIND_CORNER; c_in[0] = px - lox; c_in[1] = py - hiy;
         end else if (py < loy) begin
            kind_in = KIND_CORNER; c_in[0] = px - lox; c_in[1] = py - loy;
         end else begin
            kind_in = KIND_FACE; c_in[0] = lox - px; neg_in = 1'b1;
         end
      end else if (px > hix) begin
         if (py > hiy) begin
            kind_in = KIND_CORNER; c_in[0] = px - hix; c_in[1] = py - hiy;
         end else if (py < loy) begin
            kind_in = KIND_CORNER; c_in[0] = px - hix; c_in[1] = py - loy;
         end else begin
            kind_in = KIND_FACE; c_in[0] = px - hix;
         end
      end else if (py < loy) begin
         kind_in = KIND_FACE; c_in[0] = loy - py; axis_in = 1'b1; neg_in = 1'b1;
      end else if (py > hiy) begin
         kind_in = KIND_FACE; c_in[0] = py - hiy; axis_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff <= kind_in;
         band_ff <= band_in;
         axis_ff <= axis_in;
         neg_ff  <= neg_in;
         c_ff    <= c_in;
      end
   end

   // Nearest face: first candidate wins ties
   always_comb begin
      best = c_ff[0];
      bi   = 2'd0;
      for (int i = 1; i < 4; i++) begin
         if (magnitude(c_ff[i]) < magnitude(best)) begin
            best = c_ff[i];
            bi   = 2'(i);
         end
      end
      nearv = band_ff ? -best : best;
   end

   // Corner scaling: fewest right shifts that bring both parts below 2^31
   always_comb begin
      ax = magnitude(c_ff[0]);
      ay = magnitude(c_ff[1]);
      am = ax | ay;
      if (am[EXT_WIDTH-1:SMALL_WIDTH] == '0) sh = 2'd0;
      else if (am[EXT_WIDTH-1:SMALL_WIDTH+1] == '0) sh = 2'd1;
      else if (am[EXT_WIDTH-1:SMALL_WIDTH+2] == '0) sh = 2'd2;
      else sh = 2'd3;
      shx = ax >> sh;
      shy = ay >> sh;
   end

   // Stage 2 result
   always_comb begin
      side_in = '0;
      case (kind_ff)
         KIND_NEAR: begin
            side_in.face_dist = sat_dist(nearv);
            side_in.nx        = bi[1] ? '0 : axis_unit(bi[0] ^ band_ff);
            side_in.ny        = bi[1] ? axis_unit(bi[0] ^ band_ff) : '0;
         end
         KIND_FACE: begin
            side_in.face_dist = sat_dist(c_ff[0]);
            side_in.nx        = axis_ff ? '0 : axis_unit(neg_ff);
            side_in.ny        = axis_ff ? axis_unit(neg_ff) : '0;
         end
         KIND_CORNER: begin
            side_in.corner = 1'b1;
            side_in.big    = (sh != 2'd0);
            side_in.neg_x  = c_ff[0][EXT_WIDTH-1];
            side_in.neg_y  = c_ff[1][EXT_WIDTH-1];
            side_in.sx     = shx[SMALL_WIDTH-1:0];
            side_in.sy     = shy[SMALL_WIDTH-1:0];
         end
         default: side_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) side_ff <= side_in;
   end

   assign out_valid = v2_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

>>> rtl/core/pbcq_sqrt.sv
`default_nettype none

module pbcq_sqrt import pbcq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [RAD_WIDTH-1:0]  in_rad,
   input  pbcq_side_type         in_side,
   output logic                  out_valid,
   output logic [ROOT_WIDTH-1:0] out_root,
   output pbcq_side_type         out_side
);

   // One root bit per stage, most significant first
   logic                  v_ff    [ROOT_WIDTH];
   logic [RAD_WIDTH-1:0]  rad_ff  [ROOT_WIDTH];
   logic [REM_WIDTH-1:0]  rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];
   pbcq_side_type         side_ff [ROOT_WIDTH];

   for (genvar s = 0; s < ROOT_WIDTH; s++) begin : g_step
      localparam int K = ROOT_WIDTH - 1 - s;
      logic                  cur_v;
      logic [RAD_WIDTH-1:0]  cur_rad;
      logic [REM_WIDTH-1:0]  cur_rem;
      logic [ROOT_WIDTH-1:0] cur_root;
      pbcq_side_type         cur_side;
      logic [REM_WIDTH+1:0]  shifted, trial;
      logic                  fits;

      if (s == 0) begin : g_first
         assign cur_v    = in_valid;
         assign cur_rad  = in_rad;
         assign cur_rem  = '0;
         assign cur_root = '0;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_v    = v_ff[s-1];
         assign cur_rad  = rad_ff[s-1];
         assign cur_rem  = rem_ff[s-1];
         assign cur_root = root_ff[s-1];
         assign cur_side = side_ff[s-1];
      end

      // trial subtract of 4*root+1 from the remainder with the next bit pair
      assign shifted = {cur_rem, cur_rad[2*K+1:2*K]};
      assign trial   = shifted - {2'b00, cur_root, 2'b01};
      assign fits    = !trial[REM_WIDTH+1];

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (adv) v_ff[s] <= cur_v;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[s]  <= cur_rad;
            rem_ff[s]  <= fits ? trial[REM_WIDTH-1:0] : shifted[REM_WIDTH-1:0];
            root_ff[s] <= {cur_root[ROOT_WIDTH-2:0], fits};
            side_ff[s] <= cur_side;
         end
      end
   end

   assign out_valid = v_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];
   assign out_side  = side_ff[ROOT_WIDTH-1];

endmodule

`default_nettype wire

>>> rtl/core/pbcq_div.sv
`default_nettype none

module pbcq_div import pbcq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [ROOT_WIDTH-1:0] in_root,
   input  pbcq_side_type         in_side,
   output logic                  out_valid,
   output logic [ROOT_WIDTH-1:0] out_den,
   output logic [QUOT_WIDTH-1:0] out_qx,
   output logic [QUOT_WIDTH-1:0] out_qy,
   output pbcq_side_type         out_side
);

   // Set-up: divisor never zero, numerators carry half the divisor for rounding
   logic [ROOT_WIDTH-1:0] den;
   logic                  pv_ff;
   logic [ROOT_WIDTH-1:0] pd_ff;
   logic [NUM_WIDTH-1:0]  pnx_in, pny_in, pnx_ff, pny_ff;
   pbcq_side_type         pside_ff;

   assign den    = (in_root == '0) ? ROOT_WIDTH'(1) : in_root;
   assign pnx_in = (NUM_WIDTH'(in_side.sx) << NORMAL_FRAC_BITS) + NUM_WIDTH'(den >> 1);
   assign pny_in = (NUM_WIDTH'(in_side.sy) << NORMAL_FRAC_BITS) + NUM_WIDTH'(den >> 1);

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else if (adv) pv_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pd_ff    <= den;
         pnx_ff   <= pnx_in;
         pny_ff   <= pny_in;
         pside_ff <= in_side;
      end
   end

   // Restoring division, one quotient bit per stage for both components
   logic                  v_ff    [QUOT_WIDTH];
   logic [ROOT_WIDTH-1:0] d_ff    [QUOT_WIDTH];
   logic [NUM_WIDTH-1:0]  rx_ff   [QUOT_WIDTH];
   logic [NUM_WIDTH-1:0]  ry_ff   [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] qx_ff   [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] qy_ff   [QUOT_WIDTH];
   pbcq_side_type         side_ff [QUOT_WIDTH];

   for (genvar s = 0; s < QUOT_WIDTH; s++) begin : g_step
      localparam int K = QUOT_WIDTH - 1 - s;
      logic                  cur_v;
      logic [ROOT_WIDTH-1:0] cur_d;
      logic [NUM_WIDTH-1:0]  cur_rx, cur_ry, dk;
      logic [QUOT_WIDTH-1:0] cur_qx, cur_qy;
      pbcq_side_type         cur_side;
      logic                  fx, fy;

      if (s == 0) begin : g_first
         assign cur_v    = pv_ff;
         assign cur_d    = pd_ff;
         assign cur_rx   = pnx_ff;
         assign cur_ry   = pny_ff;
         assign cur_qx   = '0;
         assign cur_qy   = '0;
         assign cur_side = pside_ff;
      end else begin : g_next
         assign cur_v    = v_ff[s-1];
         assign cur_d    = d_ff[s-1];
         assign cur_rx   = rx_ff[s-1];
         assign cur_ry   = ry_ff[s-1];
         assign cur_qx   = qx_ff[s-1];
         assign cur_qy   = qy_ff[s-1];
         assign cur_side = side_ff[s-1];
      end

      assign dk = NUM_WIDTH'(cur_d) << K;
      assign fx = (cur_rx >= dk);
      assign fy = (cur_ry >= dk);

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (adv) v_ff[s] <= cur_v;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[s]    <= cur_d;
            rx_ff[s]   <= fx ? cur_rx - dk : cur_rx;
            ry_ff[s]   <= fy ? cur_ry - dk : cur_ry;
            qx_ff[s]   <= {cur_qx[QUOT_WIDTH-2:0], fx};
            qy_ff[s]   <= {cur_qy[QUOT_WIDTH-2:0], fy};
            side_ff[s] <= cur_side;
         end
      end
   end

   assign out_valid = v_ff[QUOT_WIDTH-1];
   assign out_den   = d_ff[QUOT_WIDTH-1];
   assign out_qx    = qx_ff[QUOT_WIDTH-1];
   assign out_qy    = qy_ff[QUOT_WIDTH-1];
   assign out_side  = side_ff[QUOT_WIDTH-1];

endmodule

`default_nettype wire

>>> rtl/core/point_box_collision_query.sv
// Pipeline stages, in order: classify 2, square 1, sum 1, root 32, divide set-up 1,
// divide 15, output 1.
// Throughput: one item per cycle; the whole pipeline holds only while a result waits.
// Reset clears all valid bits and sets the box to zero and the margin to 10.0.
`default_nettype none

module point_box_collision_query import pbcq_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // query items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DIST_WIDTH-1:0]  rsp_distance,
   output logic signed [NORM_WIDTH-1:0]  rsp_normal_x,
   output logic signed [NORM_WIDTH-1:0]  rsp_normal_y,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ADDR_WIDTH-1:0]         paddr,
   input  logic [DATA_WIDTH-1:0]         pwdata,
   output logic [DATA_WIDTH-1:0]         prdata,
   output logic                          pready
);

   logic                          adv;
   logic signed [COORD_WIDTH-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [MARGIN_WIDTH-1:0]       margin_ff;
   pbcq_reg_type                  reg_sel;

   // Registers
   assign pready  = 1'b1;
   assign reg_sel = pbcq_reg_type'(paddr[ADDR_WIDTH-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff  <= '0;
         min_y_ff  <= '0;
         max_x_ff  <= '0;
         max_y_ff  <= '0;
         margin_ff <= MARGIN_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_sel)
            REG_MIN_X:  min_x_ff  <= pwdata[COORD_WIDTH-1:0];
            REG_MIN_Y:  min_y_ff  <= pwdata[COORD_WIDTH-1:0];
            REG_MAX_X:  max_x_ff  <= pwdata[COORD_WIDTH-1:0];
            REG_MAX_Y:  max_y_ff  <= pwdata[COORD_WIDTH-1:0];
            REG_MARGIN: margin_ff <= pwdata[MARGIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MIN_X:  prdata = DATA_WIDTH'(min_x_ff);
         REG_MIN_Y:  prdata = DATA_WIDTH'(min_y_ff);
         REG_MAX_X:  prdata = DATA_WIDTH'(max_x_ff);
         REG_MAX_Y:  prdata = DATA_WIDTH'(max_y_ff);
         REG_MARGIN: prdata = DATA_WIDTH'(margin_ff);
         default:    prdata = '0;
      endcase
   end

   // Whole pipeline moves unless the output register holds an untaken item
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Classification
   logic          cl_valid;
   pbcq_side_type cl_side;

   pbcq_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .box_min_x (min_x_ff),
      .box_min_y (min_y_ff),
      .box_max_x (max_x_ff),
      .box_max_y (max_y_ff),
      .margin    (margin_ff),
      .out_valid (cl_valid),
      .out_side  (cl_side)
   );

   // Squares, then their sum
   logic                     sq_v_ff, sum_v_ff;
   logic [2*SMALL_WIDTH-1:0] sqx_ff, sqy_ff;
   logic [RAD_WIDTH-1:0]     rad_ff;
   pbcq_side_type            sq_side_ff, sum_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= 1'b0;
         sum_v_ff <= 1'b0;
      end else if (adv) begin
         sq_v_ff  <= cl_valid;
         sum_v_ff <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff      <= (2*SMALL_WIDTH)'(cl_side.sx) * (2*SMALL_WIDTH)'(cl_side.sx);
         sqy_ff      <= (2*SMALL_WIDTH)'(cl_side.sy) * (2*SMALL_WIDTH)'(cl_side.sy);
         sq_side_ff  <= cl_side;
         rad_ff      <= RAD_WIDTH'(sqx_ff) + RAD_WIDTH'(sqy_ff);
         sum_side_ff <= sq_side_ff;
      end
   end

   // Corner distance
   logic                  rt_valid;
   logic [ROOT_WIDTH-1:0] rt_root;
   pbcq_side_type         rt_side;

   pbcq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sum_v_ff),
      .in_rad    (rad_ff),
      .in_side   (sum_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // Corner normal
   logic                  dv_valid;
   logic [ROOT_WIDTH-1:0] dv_den;
   logic [QUOT_WIDTH-1:0] dv_qx, dv_qy;
   pbcq_side_type         dv_side;

   pbcq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (rt_valid),
      .in_root   (rt_root),
      .in_side   (rt_side),
      .out_valid (dv_valid),
      .out_den   (dv_den),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_side  (dv_side)
   );

   // Output register
   logic                  out_v_ff;
   logic [DIST_WIDTH-1:0] dist_in, dist_ff;
   logic [NORM_WIDTH-1:0] nx_in, ny_in, nx_ff, ny_ff, qx, qy;

   assign qx = NORM_WIDTH'(dv_qx);
   assign qy = NORM_WIDTH'(dv_qy);

   always_comb begin
      if (dv_side.corner) begin
         if (dv_side.big || dv_den[ROOT_WIDTH-1]) dist_in = DIST_MAX;
         else dist_in = dv_den[DIST_WIDTH-1:0];
         nx_in = dv_side.neg_x ? (~qx + NORM_WIDTH'(1)) : qx;
         ny_in = dv_side.neg_y ? (~qy + NORM_WIDTH'(1)) : qy;
      end else begin
         dist_in = dv_side.face_dist;
         nx_in   = dv_side.nx;
         ny_in   = dv_side.ny;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= dv_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dist_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_distance = dist_ff;
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;

endmodule

`default_nettype wire
